>>> rtl/core/rfx_pkg.sv
// Shared constants, codes and payload types of the ring FIFO with extract.
package rfx_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned CfgW      = 5;

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_POP     = 2'd1,
    REQ_EXTRACT = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_EMPTY    = 2'd2,
    STS_NO_MATCH = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [DataWidth-1:0] item_value;
  } rfx_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [DataWidth-1:0] item_out;
    logic [CntW-1:0]      removed_count;
    logic [CntW-1:0]      occupancy;
    logic [CntW-1:0]      high_water;
  } rfx_rsp_t;

endpackage

>>> rtl/core/ring_fifo_with_extract.sv
// Top level of the ring FIFO with push, pop and extract-all-equal requests.
//
// Usage: drive req_i and raise start; the request transfers at a clock edge
// with start high and busy low. Each request yields one result on rsp_o,
// shown for exactly one cycle with done_o high; the receiver cannot stall,
// so the result must be taken in that cycle.
// Request handling, set by the synchronous ring memory (one write port,
// one registered read port):
//   push, unused code, full/empty answers: result in the cycle after the
//     transfer, next request may transfer in the following cycle.
//   pop: the head word passes the registered read port, then S_POP, where
//     the result is registered; busy in S_POP, so no request transfers until the result shows.
//   extract: the walk issues one memory read per held entry and writes the
//     kept words back behind the read pointer; busy until the result shows.
// Configuration: cfg_we_i with cfg_wdata_i sets the capacity in use (0 counts
// as 1, values above the built depth count as the depth) and empties the
// ring; the peak occupancy is kept. Write only while idle.
// Reset: head, occupancy, peak go to zero and the capacity to the full
// depth; the ring memory holds no reset value and needs no clearing pass.
module ring_fifo_with_extract import rfx_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rfx_req_t        req_i,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output logic            done_o,
  output rfx_rsp_t        rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_EXT  = 2'd2;

  // Ring memory, one write and one registered read port
  logic [DataWidth-1:0] mem [Depth];
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  logic [DataWidth-1:0] mem_wdata;
  logic [IdxW-1:0]      mem_raddr;
  logic [DataWidth-1:0] rd_q;

  logic [1:0]           state_q, state_d;
  logic [IdxW-1:0]      head_q, head_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      peak_q, peak_d;
  logic [CntW-1:0]      cap_q, cap_d;
  logic [IdxW-1:0]      src_q, src_d;
  logic [IdxW-1:0]      dst_q, dst_d;
  logic [CntW-1:0]      left_q, left_d;
  logic [CntW-1:0]      removed_q, removed_d;
  logic                 pend_q, pend_d;
  logic [DataWidth-1:0] item_q, item_d;
  logic                 done_q, done_d;
  rfx_rsp_t             rsp_q, rsp_d;

  logic            accept;
  logic [IdxW-1:0] push_idx, head_inc, src_inc, dst_inc;
  logic [CntW-1:0] new_cnt;
  logic [CntW-1:0] cfg_cap;
  logic            match;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
  assign match  = (rd_q == item_q);

  rfx_wrap u_wrap_push (.idx_i(head_q), .inc_i(cnt_q), .cap_i(cap_q), .idx_o(push_idx));
  rfx_wrap u_wrap_head (.idx_i(head_q), .inc_i(CntW'(1)), .cap_i(cap_q), .idx_o(head_inc));
  rfx_wrap u_wrap_src  (.idx_i(src_q), .inc_i(CntW'(1)), .cap_i(cap_q), .idx_o(src_inc));
  rfx_wrap u_wrap_dst  (.idx_i(dst_q), .inc_i(CntW'(1)), .cap_i(cap_q), .idx_o(dst_inc));

  // Clamp the written capacity into 1..Depth
  always_comb begin
    cfg_cap = cfg_wdata_i[CntW-1:0];
    if (cfg_wdata_i == '0) begin
      cfg_cap = CntW'(1);
    end else if ({1'b0, cfg_wdata_i} > (CfgW + 1)'(Depth)) begin
      cfg_cap = CntW'(Depth);
    end
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    peak_d    = peak_q;
    cap_d     = cap_q;
    src_d     = src_q;
    dst_d     = dst_q;
    left_d    = left_q;
    removed_d = removed_q;
    pend_d    = 1'b0;
    item_d    = item_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = push_idx;
    mem_wdata = req_i.item_value;
    mem_raddr = head_q;
    new_cnt   = cnt_q;

    case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          cap_d  = cfg_cap;
          head_d = '0;
          cnt_d  = '0;
        end else if (accept) begin
          rsp_d.item_out      = req_i.item_value;
          rsp_d.status        = STS_OK;
          rsp_d.removed_count = '0;
          rsp_d.occupancy     = cnt_q;
          rsp_d.high_water    = peak_q;
          case (req_i.req_type)
            REQ_PUSH: begin
              done_d = 1'b1;
              if (cnt_q >= cap_q) begin
                rsp_d.status   = STS_FULL;
                rsp_d.item_out = '0;
              end else begin
                mem_we  = 1'b1;
                new_cnt = cnt_q + CntW'(1);
                cnt_d   = new_cnt;
                if (new_cnt > peak_q) begin
                  peak_d = new_cnt;
                end
                rsp_d.occupancy  = new_cnt;
                rsp_d.high_water = (new_cnt > peak_q) ? new_cnt : peak_q;
              end
            end
            REQ_POP: begin
              if (cnt_q == '0) begin
                done_d         = 1'b1;
                rsp_d.status   = STS_EMPTY;
                rsp_d.item_out = '0;
              end else begin
                // head word arrives from memory next cycle
                head_d          = head_inc;
                cnt_d           = cnt_q - CntW'(1);
                rsp_d.occupancy = cnt_q - CntW'(1);
                state_d         = S_POP;
              end
            end
            REQ_EXTRACT: begin
              item_d    = req_i.item_value;
              src_d     = head_q;
              dst_d     = head_q;
              left_d    = cnt_q;
              removed_d = '0;
              state_d   = S_EXT;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        rsp_d.item_out = rd_q;
        done_d         = 1'b1;
        state_d        = S_IDLE;
      end
      S_EXT: begin
        mem_raddr = src_q;
        mem_waddr = dst_q;
        mem_wdata = rd_q;
        // retire the word read last cycle: drop on match, else pack it at dst
        if (pend_q) begin
          if (match) begin
            removed_d = removed_q + CntW'(1);
          end else begin
            mem_we = 1'b1;
            dst_d  = dst_inc;
          end
        end
        // issue the next read; writes trail reads so no entry is overwritten early
        if (left_q != '0) begin
          src_d  = src_inc;
          left_d = left_q - CntW'(1);
          pend_d = 1'b1;
        end else if (!pend_q) begin
          new_cnt             = cnt_q - removed_q;
          cnt_d               = new_cnt;
          done_d              = 1'b1;
          state_d             = S_IDLE;
          rsp_d.removed_count = removed_q;
          rsp_d.occupancy     = new_cnt;
          rsp_d.high_water    = peak_q;
          if (removed_q == '0) begin
            rsp_d.status   = STS_NO_MATCH;
            rsp_d.item_out = '0;
          end else begin
            rsp_d.status   = STS_OK;
            rsp_d.item_out = item_q;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      cnt_q     <= '0;
      peak_q    <= '0;
      cap_q     <= CntW'(Depth);
      src_q     <= '0;
      dst_q     <= '0;
      left_q    <= '0;
      removed_q <= '0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      peak_q    <= peak_d;
      cap_q     <= cap_d;
      src_q     <= src_d;
      dst_q     <= dst_d;
      left_q    <= left_d;
      removed_q <= removed_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rsp_q  <= rsp_d;
  end

  a_cnt_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cap_q)
    else $error("occupancy above capacity");

  a_head_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, head_q} < {1'b0, cap_q})
    else $error("head index outside the ring");

  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= cnt_q)
    else $error("peak below occupancy");

  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_EXT))
    else $error("read in flight outside the extract walk");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(accept) || $past(busy)))
    else $error("result without a request");

endmodule

>>> rtl/core/rfx_wrap.sv
// Ring index advance modulo the capacity in use.
module rfx_wrap import rfx_pkg::*; (
  input  logic [IdxW-1:0] idx_i,
  input  logic [CntW-1:0] inc_i,
  input  logic [CntW-1:0] cap_i,
  output logic [IdxW-1:0] idx_o
);

  logic [CntW:0] sum;
  logic [CntW:0] diff;

  // idx < cap and inc <= cap, so one subtract is enough
  assign sum   = {{(CntW + 1 - IdxW){1'b0}}, idx_i} + {1'b0, inc_i};
  assign diff  = sum - {1'b0, cap_i};
  assign idx_o = (sum >= {1'b0, cap_i}) ? diff[IdxW-1:0] : sum[IdxW-1:0];

endmodule
